FILE: rtl/srsw_pkg.sv
package srsw_pkg;

  localparam int unsigned WindowDefault = 8;
  localparam int unsigned MaxResults    = 8;
  localparam logic [15:0] TimeoutReset  = 16'd3000;

  localparam int unsigned SeqW   = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 4;
  localparam int unsigned StampW = 32;
  localparam int unsigned TimeoutW = 16;

  typedef enum logic [1:0] {
    CMD_NEW  = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NEW    = 3'd0,
    EV_RETX   = 3'd1,
    EV_REFUSE = 3'd2,
    EV_ACK    = 3'd3,
    EV_IGNORE = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_SCAN,
    ST_RELEASE,
    ST_TICK_SCAN,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    cmd_t             command;
    logic [ByteW-1:0] payload_byte;
    logic [SeqW-1:0]  ack_number;
    logic             ack_ok;
  } in_item_t;

  typedef struct packed {
    event_t            event_res;
    logic [SeqW-1:0]   seq_number;
    logic [ByteW-1:0]  frame_byte;
    logic [CountW-1:0] released;
    logic [CountW-1:0] occupancy;
    logic              last;
  } out_item_t;

  // One window entry as it moves along the cell row
  typedef struct packed {
    logic              occ;
    logic              acked;
    logic [SeqW-1:0]   seq;
    logic [ByteW-1:0]  data;
    logic [StampW-1:0] stamp;
  } entry_t;

endpackage

FILE: rtl/srsw_chan_if.sv
interface srsw_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/srsw_cell.sv
module srsw_cell
  import srsw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cell_op_t op,
  input  entry_t   nbr,
  input  entry_t   wr,
  output entry_t   q
);

  entry_t sel;

  always_comb begin
    case (op)
      CELL_TAKE:  sel = nbr;
      CELL_WRITE: sel = wr;
      default:    sel = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.occ   <= 1'b0;
      q.acked <= 1'b0;
    end else begin
      q.occ   <= sel.occ;
      q.acked <= sel.acked;
    end
  end

  always_ff @(posedge clk) begin
    q.seq   <= sel.seq;
    q.data  <= sel.data;
    q.stamp <= sel.stamp;
  end

endmodule

FILE: rtl/selective_repeat_sender_window.sv
// Channel  Dir  Payload     Transfer
// item     in   in_item_t   valid & ready
// result   out  out_item_t  valid & ready
// cfg      in   timeout_ms  cfg_wr_en
//
// A new byte goes from idle through the flush state. An applied acknowledgement scans the window,
// then releases acknowledged entries from the front and flushes; an ignored one scans and flushes,
// or flushes at once when it fails its check. A tick scans, then flushes only if a retransmit was
// due. Each scan is one full rotation of the window through the front cell of the row.
// rst clears the window, the counters and the clock, and loads timeout_ms with 3000.
// A tick scan pauses only when a retransmit is found while an earlier one is pending and the result output is stalled.
// WINDOW ranges from 1 to 8, bounded by the 4-bit sequence and occupancy fields.
module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int unsigned WINDOW = WindowDefault
) (
  input  logic                clk,
  input  logic                rst,
  srsw_chan_if.sink           item,
  srsw_chan_if.source         result,
  input  logic                cfg_wr_en,
  input  logic [TimeoutW-1:0] cfg_wr_data
);

  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned StepW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NresW = $clog2(MaxResults + 1);

  state_t              state, state_next;
  logic [CntW-1:0]     count, count_next;
  logic [SeqW-1:0]     next_seq, next_seq_next;
  logic [StampW-1:0]   now_ms, now_ms_next;
  logic [TimeoutW-1:0] timeout_ms;
  logic [StepW-1:0]    step, step_next;
  logic [NresW-1:0]    nres, nres_next;
  logic                found, found_next;
  logic [CntW-1:0]     rel, rel_next;
  logic [SeqW-1:0]     ack_num, ack_num_next;
  out_item_t           pend, pend_next;
  logic                pend_valid, pend_valid_next;
  out_item_t           res, res_next;
  logic                res_valid, res_valid_next;

  logic     chain_go;
  logic     rotate;
  logic     wr_go;
  entry_t   head_fix;
  entry_t   tail;
  entry_t   wr_entry;
  entry_t   q   [WINDOW];
  entry_t   nbr [WINDOW];
  cell_op_t op  [WINDOW];

  logic out_free;
  logic last_step;
  logic match;
  logic due;

  assign out_free  = !res_valid || result.ready;
  assign last_step = (step == StepW'(WINDOW - 1));
  assign match = q[0].occ && !q[0].acked && (q[0].seq == ack_num) && !found;
  assign due   = q[0].occ && !q[0].acked && (nres < NresW'(MaxResults)) &&
                 ((now_ms - q[0].stamp) > {{(StampW-TimeoutW){1'b0}}, timeout_ms});

  assign item.ready     = (state == ST_IDLE);
  assign result.valid   = res_valid;
  assign result.payload = res;

  assign wr_entry = '{occ: 1'b1, acked: 1'b0, seq: next_seq,
                      data: item.payload.payload_byte, stamp: now_ms};

  // Front entry as it re-enters at the back of the ring
  always_comb begin
    head_fix = q[0];
    if (state == ST_ACK_SCAN) begin
      head_fix.acked = q[0].acked | match;
    end
    if (state == ST_TICK_SCAN && due) begin
      head_fix.stamp = now_ms;
    end
  end

  always_comb begin
    tail = '0;
    if (rotate) begin
      tail = head_fix;
    end
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == WINDOW - 1) begin : g_tail
      assign nbr[i] = tail;
    end else begin : g_mid
      assign nbr[i] = q[i+1];
    end

    assign op[i] = (wr_go && count == CntW'(i)) ? CELL_WRITE :
                   chain_go                     ? CELL_TAKE  : CELL_HOLD;

    srsw_cell u_cell (
      .clk (clk),
      .rst (rst),
      .op  (op[i]),
      .nbr (nbr[i]),
      .wr  (wr_entry),
      .q   (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      next_seq   <= '0;
      now_ms     <= '0;
      timeout_ms <= TimeoutReset;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      count      <= count_next;
      next_seq   <= next_seq_next;
      now_ms     <= now_ms_next;
      pend_valid <= pend_valid_next;
      res_valid  <= res_valid_next;
      if (cfg_wr_en) begin
        timeout_ms <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    step    <= step_next;
    nres    <= nres_next;
    found   <= found_next;
    rel     <= rel_next;
    ack_num <= ack_num_next;
    pend    <= pend_next;
    res     <= res_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    next_seq_next   = next_seq;
    now_ms_next     = now_ms;
    step_next       = step;
    nres_next       = nres;
    found_next      = found;
    rel_next        = rel;
    ack_num_next    = ack_num;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    res_next        = res;
    res_valid_next  = res_valid && !result.ready;
    chain_go        = 1'b0;
    rotate          = 1'b0;
    wr_go           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (item.valid) begin
          case (item.payload.command)
            CMD_NEW: begin
              pend_next.frame_byte = item.payload.payload_byte;
              pend_next.seq_number = next_seq;
              pend_next.released   = '0;
              pend_next.last       = 1'b0;
              pend_valid_next      = 1'b1;
              state_next           = ST_FLUSH;
              if (count == CntW'(WINDOW)) begin
                pend_next.event_res = EV_REFUSE;
                pend_next.occupancy = CountW'(count);
              end else begin
                wr_go               = 1'b1;
                count_next          = count + 1'b1;
                next_seq_next       = (next_seq == SeqW'(2 * WINDOW - 1)) ? '0 :
                                      next_seq + 1'b1;
                pend_next.event_res = EV_NEW;
                pend_next.occupancy = CountW'(count + 1'b1);
              end
            end
            CMD_ACK: begin
              ack_num_next = item.payload.ack_number;
              step_next    = '0;
              found_next   = 1'b0;
              if (item.payload.ack_ok) begin
                state_next = ST_ACK_SCAN;
              end else begin
                pend_next       = '{event_res: EV_IGNORE,
                                    seq_number: item.payload.ack_number,
                                    frame_byte: '0, released: '0,
                                    occupancy: CountW'(count), last: 1'b0};
                pend_valid_next = 1'b1;
                state_next      = ST_FLUSH;
              end
            end
            CMD_TICK: begin
              now_ms_next     = now_ms + 1'b1;
              step_next       = '0;
              nres_next       = '0;
              pend_valid_next = 1'b0;
              state_next      = ST_TICK_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_ACK_SCAN: begin
        chain_go   = 1'b1;
        rotate     = 1'b1;
        found_next = found | match;
        step_next  = step + 1'b1;
        if (last_step) begin
          if (found || match) begin
            rel_next   = '0;
            state_next = ST_RELEASE;
          end else begin
            pend_next       = '{event_res: EV_IGNORE, seq_number: ack_num,
                                frame_byte: '0, released: '0,
                                occupancy: CountW'(count), last: 1'b0};
            pend_valid_next = 1'b1;
            state_next      = ST_FLUSH;
          end
        end
      end

      ST_RELEASE: begin
        if (q[0].occ && q[0].acked) begin
          // drop the front entry, the row shifts toward the front
          chain_go   = 1'b1;
          count_next = count - 1'b1;
          rel_next   = rel + 1'b1;
        end else begin
          pend_next       = '{event_res: EV_ACK, seq_number: ack_num,
                              frame_byte: '0, released: CountW'(rel),
                              occupancy: CountW'(count), last: 1'b0};
          pend_valid_next = 1'b1;
          state_next      = ST_FLUSH;
        end
      end

      ST_TICK_SCAN: begin
        if (!(due && pend_valid && !out_free)) begin
          chain_go  = 1'b1;
          rotate    = 1'b1;
          step_next = step + 1'b1;
          if (due) begin
            if (pend_valid) begin
              res_next       = pend;
              res_valid_next = 1'b1;
            end
            pend_next       = '{event_res: EV_RETX, seq_number: q[0].seq,
                                frame_byte: q[0].data, released: '0,
                                occupancy: CountW'(count), last: 1'b0};
            pend_valid_next = 1'b1;
            nres_next       = nres + 1'b1;
          end
          if (last_step) begin
            state_next = (pend_valid || due) ? ST_FLUSH : ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          res_next        = pend;
          res_next.last   = 1'b1;
          res_valid_next  = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/srsw_checker.sv
module srsw_checker
  import srsw_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input cmd_t      item_cmd,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res
);

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // any real command closes the input in the next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_cmd != CMD_RSVD |=> !item_ready)
    else $error("input taken again right after a command");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res != EV_RETX |-> res.last)
    else $error("single-result event without last");

  a_release_only_on_ack: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res != EV_ACK |-> res.released == '0)
    else $error("released count outside an applied ack");

  a_new_occupies: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == EV_NEW |-> res.occupancy != '0)
    else $error("new transfer with empty window");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .item_cmd   (item.payload.command),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res        (result.payload)
);
